// ===== design/sfir_pkg.sv =====
// Shared constants and types for the stereo FIR filter core.
`default_nettype none

package sfir_pkg;

    // Width of each channel's running sum; every add saturates to this range.
    localparam int ACC_BITS = 48;

    // Item kind carried in s_axis_tuser.
    typedef enum logic [0:0] {
        FUNC_SAMPLE = 1'b0,
        FUNC_LOAD   = 1'b1
    } t_func;

    // Width of the tap index field in the input beat.
    localparam int TAP_INDEX_BITS = 8;

endpackage

`default_nettype wire

// ===== design/stereo_fir_filter_core.sv =====
// Stereo FIR filter core: shared tap memory, two history lines, one MAC per channel.
//
// Input channel (s_axis): one beat is either a tap load (tuser = load) or a
// stereo sample pair (tuser = sample). A load writes one coefficient and
// gives no output; the core is ready again on the next cycle. Loads with a
// tap index at or beyond TAPS are dropped. All taps must be loaded before
// samples are sent.
// Output channel (m_axis): one beat per sample pair, left and right filtered
// samples in tdata, per-channel clip flags in tuser.
// A sample pair holds tready low until its result has been written to the
// output register, so no new beat is taken while a pair is filtered. The
// per-channel multiply-accumulate walks the taps one per cycle, reading the
// tap memory and the history memory once each, then a flush through the
// read, multiply and add stages and a round-and-saturate step.
// The result sits in an output register; new input beats are taken while it
// waits. If the receiver still holds the previous result when the next one
// is ready, the core waits (tready low) until that beat is taken.
// Reset (synchronous, active low) empties the history lines (via a fill
// count, no memory sweep), rewinds the write pointer and drops any pending
// output. Tap memory contents are not affected by reset.
`default_nettype none

module stereo_fir_filter_core #(
    parameter int TAPS        = 256,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 18,
    localparam int S_TDATA_W  =
        ((sfir_pkg::TAP_INDEX_BITS + COEF_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // tap_index, tap_value, left_in, right_in (lowest bit first), zero pad
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // func
    input  wire logic [0:0]           s_axis_tuser,

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // left_out, right_out (lowest bit first), zero pad
    output logic      [M_TDATA_W-1:0] m_axis_tdata,
    // clipped: bit0 left, bit1 right
    output logic      [1:0]           m_axis_tuser
);

    localparam int IB     = sfir_pkg::TAP_INDEX_BITS;
    localparam int ACC_W  = sfir_pkg::ACC_BITS;
    localparam int IDX_W  = $clog2(TAPS);
    localparam int FILL_W = $clog2(TAPS + 1);
    localparam int FRAC   = COEF_BITS - 2;
    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
    localparam int SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
    localparam int RND_W  = ACC_W + 1;

    localparam logic signed [SUM_W-1:0] ACC_MAX =
        {{(SUM_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;
    localparam logic signed [RND_W-1:0] OUT_MAX =
        {{(RND_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [RND_W-1:0] OUT_MIN = ~OUT_MAX;
    localparam logic signed [RND_W-1:0] RND_HALF =
        {{(RND_W - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_state;

    // input field split
    logic        [IB-1:0]          w_tap_index;
    logic signed [COEF_BITS-1:0]   w_tap_value;
    logic signed [SAMPLE_BITS-1:0] w_left_in;
    logic signed [SAMPLE_BITS-1:0] w_right_in;

    assign w_tap_index = s_axis_tdata[IB-1:0];
    assign w_tap_value = s_axis_tdata[IB +: COEF_BITS];
    assign w_left_in   = s_axis_tdata[IB + COEF_BITS +: SAMPLE_BITS];
    assign w_right_in  = s_axis_tdata[IB + COEF_BITS + SAMPLE_BITS +: SAMPLE_BITS];

    t_state                  r_state;
    logic [IDX_W-1:0]        r_wp;
    logic [FILL_W-1:0]       r_fill;
    logic [IDX_W-1:0]        r_k;
    logic [IDX_W-1:0]        r_slot;
    logic                    r_v1;
    logic                    r_z1;
    logic                    r_v2;
    logic signed [PROD_W-1:0] r_prod_l;
    logic signed [PROD_W-1:0] r_prod_r;
    logic signed [ACC_W-1:0] r_acc_l;
    logic signed [ACC_W-1:0] r_acc_r;
    logic                    r_m_valid;
    logic [M_TDATA_W-1:0]    r_m_data;
    logic [1:0]              r_m_clip;

    logic w_accept;
    logic w_load;
    logic w_sample;
    logic w_coef_we;
    logic w_zero;
    logic w_out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_load     = w_accept && (s_axis_tuser == sfir_pkg::FUNC_LOAD);
    assign w_sample   = w_accept && (s_axis_tuser == sfir_pkg::FUNC_SAMPLE);
    assign w_coef_we  = w_load && (32'(w_tap_index) < TAPS);
    // history slots not yet written since reset read as zero
    assign w_zero     = (FILL_W'(r_k) >= r_fill);
    assign w_out_free = !r_m_valid || m_axis_tready;

    logic signed [COEF_BITS-1:0]     w_coef;
    logic        [2*SAMPLE_BITS-1:0] w_hist;

    sfir_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (IDX_W'(w_tap_index)),
        .i_wdata (w_tap_value),
        .i_raddr (r_k),
        .o_rdata (w_coef)
    );

    sfir_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_sample),
        .i_waddr (r_wp),
        .i_wdata ({w_right_in, w_left_in}),
        .i_raddr (r_slot),
        .o_rdata (w_hist)
    );

    logic signed [SAMPLE_BITS-1:0] w_hist_l;
    logic signed [SAMPLE_BITS-1:0] w_hist_r;

    assign w_hist_l = r_z1 ? '0 : w_hist[SAMPLE_BITS-1:0];
    assign w_hist_r = r_z1 ? '0 : w_hist[2*SAMPLE_BITS-1:SAMPLE_BITS];

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  acc,
        input logic signed [PROD_W-1:0] prod
    );
        logic signed [SUM_W-1:0] sum;
        sum = $signed({{(SUM_W - ACC_W){acc[ACC_W-1]}}, acc})
            + $signed({{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod});
        if (sum > ACC_MAX) begin
            sum = ACC_MAX;
        end else if (sum < ACC_MIN) begin
            sum = ACC_MIN;
        end
        return sum[ACC_W-1:0];
    endfunction

    // round half up by FRAC bits, then saturate to the sample width
    function automatic logic [SAMPLE_BITS:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [RND_W-1:0] val;
        logic                    hit;
        val = $signed({acc[ACC_W-1], acc}) + RND_HALF;
        val = val >>> FRAC;
        hit = 1'b0;
        if (val > OUT_MAX) begin
            val = OUT_MAX;
            hit = 1'b1;
        end else if (val < OUT_MIN) begin
            val = OUT_MIN;
            hit = 1'b1;
        end
        return {hit, val[SAMPLE_BITS-1:0]};
    endfunction

    logic [SAMPLE_BITS:0] w_res_l;
    logic [SAMPLE_BITS:0] w_res_r;

    assign w_res_l = round_sat(r_acc_l);
    assign w_res_r = round_sat(r_acc_r);

    always_ff @(posedge i_clk) begin
        // datapath, no reset needed
        r_z1     <= w_zero;
        r_prod_l <= w_coef * w_hist_l;
        r_prod_r <= w_coef * w_hist_r;
        if (w_sample) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_v2) begin
            r_acc_l <= sat_add(r_acc_l, r_prod_l);
            r_acc_r <= sat_add(r_acc_r, r_prod_r);
        end

        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_fill    <= '0;
            r_k       <= '0;
            r_slot    <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_v2 <= r_v1;
            r_v1 <= (r_state == S_RUN);
            // in S_FINISH the output register is refilled below
            if (r_m_valid && m_axis_tready && (r_state != S_FINISH)) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_sample) begin
                        r_k    <= '0;
                        r_slot <= r_wp;
                        r_wp   <= (r_wp == IDX_W'(TAPS - 1)) ? '0 : r_wp + 1'b1;
                        if (r_fill != FILL_W'(TAPS)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    // tap k pairs with the sample k frames back
                    r_k    <= r_k + 1'b1;
                    r_slot <= (r_slot == '0) ? IDX_W'(TAPS - 1) : r_slot - 1'b1;
                    if (r_k == IDX_W'(TAPS - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_v1 && !r_v2) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= M_TDATA_W'({w_res_r[SAMPLE_BITS-1:0],
                                                 w_res_l[SAMPLE_BITS-1:0]});
                        r_m_clip  <= {w_res_r[SAMPLE_BITS], w_res_l[SAMPLE_BITS]};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_clip;

endmodule

`default_nettype wire

// ===== design/sfir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sfir_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/sfir_checker.sv =====
// Port-level assertions for the stereo FIR filter core, bound to the top level.
`default_nettype none

module sfir_checker #(
    parameter int S_TDATA_W = 80,
    parameter int M_TDATA_W = 48
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input wire logic [0:0]           s_axis_tuser,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [1:0]           m_axis_tuser
);

    logic w_s_beat;
    assign w_s_beat = s_axis_tvalid && s_axis_tready;

    // a held output beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // after a tap load the core is ready again on the next cycle
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_beat && (s_axis_tuser == sfir_pkg::FUNC_LOAD) |=> s_axis_tready)
        else $error("core busy after a tap load");

    // a sample pair makes the core busy; tready is checked low once, early in the run
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_beat && (s_axis_tuser == sfir_pkg::FUNC_SAMPLE) |=> ##1 !s_axis_tready)
        else $error("core ready during a filter run");

    // a new result only appears at the end of a run
    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a filter run");

endmodule

bind stereo_fir_filter_core sfir_checker #(
    .S_TDATA_W (S_TDATA_W),
    .M_TDATA_W (M_TDATA_W)
) u_sfir_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
